/* rtl/sdas_pkg.sv */
// Shared types and constants for the same-document adjacent span suppressor.
// Used by the channel interfaces, the span cells, the cell chain and the top level.
package sdas_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word doc;
        t_word first_ln;
        t_word last_ln;
    } t_span;

    typedef struct packed {
        logic  act;
        logic  hit;
        t_span span;
    } t_probe;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_span            span;
    } t_store_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

/* rtl/sdas_ifs.sv */
// Channel interfaces for the suppressor: candidate items, verdict items and
// the max_gap write channel. Depends on sdas_pkg for the word type.
interface sdas_item_if;
    import sdas_pkg::*;
    logic  valid;
    logic  ready;
    logic  first;
    t_word candidate_id;
    t_word score_bits;
    logic  chunk_found;
    t_word doc_id;
    t_word line_lo;
    t_word line_hi;

    modport source (
        output valid, first, candidate_id, score_bits, chunk_found, doc_id,
               line_lo, line_hi,
        input  ready
    );
    modport sink (
        input  valid, first, candidate_id, score_bits, chunk_found, doc_id,
               line_lo, line_hi,
        output ready
    );
endinterface

interface sdas_verdict_if;
    import sdas_pkg::*;
    logic  valid;
    logic  ready;
    t_word out_candidate;
    t_word out_score;
    logic  keep;
    logic  overflow;

    modport source (
        output valid, out_candidate, out_score, keep, overflow,
        input  ready
    );
    modport sink (
        input  valid, out_candidate, out_score, keep, overflow,
        output ready
    );
endinterface

interface sdas_cfg_if;
    import sdas_pkg::*;
    logic  valid;
    logic  ready;
    t_word data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

/* rtl/sdas_cell.sv */
// One store cell: holds a kept span and compares it with the probe passing by.
// Depends on sdas_pkg for the span and probe types.
module sdas_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sdas_pkg::t_word  i_max_gap,
    input  logic           i_clear,
    input  logic           i_wr_en,
    input  sdas_pkg::t_span  i_wr_span,
    input  sdas_pkg::t_probe i_probe,
    output sdas_pkg::t_probe o_probe
);
    import sdas_pkg::*;

    logic   r_valid;
    t_span  r_span;
    t_probe r_probe;
    logic   w_after;
    logic   w_before;
    t_word  w_gap_after;
    t_word  w_gap_before;
    logic   w_near;
    logic   w_match;

    // The probe span lies after the stored one, before it, or overlaps it.
    assign w_after      = i_probe.span.first_ln > r_span.last_ln;
    assign w_before     = r_span.first_ln > i_probe.span.last_ln;
    assign w_gap_after  = i_probe.span.first_ln - r_span.last_ln;
    assign w_gap_before = r_span.first_ln - i_probe.span.last_ln;

    always_comb begin
        if (w_after) begin
            w_near = w_gap_after <= i_max_gap;
        end else if (w_before) begin
            w_near = w_gap_before <= i_max_gap;
        end else begin
            w_near = 1'b1;
        end
    end

    assign w_match = r_valid && (r_span.doc == i_probe.span.doc) && w_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_span <= i_wr_span;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe.hit  <= i_probe.hit || (i_probe.act && w_match);
        r_probe.span <= i_probe.span;
        if (!i_rst_n) begin
            r_probe.act <= 1'b0;
        end else begin
            r_probe.act <= i_probe.act;
        end
    end

    assign o_probe = r_probe;

endmodule

/* rtl/sdas_chain.sv */
// Row of span cells that a probe walks through, one cell per cycle.
// Decodes the store write to the addressed cell. Depends on sdas_pkg and sdas_cell.
module sdas_chain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sdas_pkg::t_word    i_max_gap,
    input  logic               i_clear,
    input  sdas_pkg::t_store_wr i_wr,
    input  sdas_pkg::t_probe   i_probe,
    output sdas_pkg::t_probe   o_probe
);
    import sdas_pkg::*;

    t_probe w_link [CAPACITY+1];

    assign w_link[0] = i_probe;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic w_wr_en;

        assign w_wr_en = i_wr.en && (i_wr.idx == IDX_W'(k));

        sdas_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_max_gap (i_max_gap),
            .i_clear   (i_clear),
            .i_wr_en   (w_wr_en),
            .i_wr_span (i_wr.span),
            .i_probe   (w_link[k]),
            .o_probe   (w_link[k+1])
        );
    end

    assign o_probe = w_link[CAPACITY];

endmodule

/* rtl/same_doc_adjacent_span_suppressor.sv */
// Top level of the same-document adjacent span suppressor.
// Depends on sdas_pkg, the channel interfaces in sdas_ifs and sdas_chain.
//
// Candidates arrive on i_in, one item per valid/ready handshake, in rank order.
// Each item yields one verdict item on o_out carrying its id, its score, the
// keep bit and the sticky overflow bit of the current list. An item with first
// set clears the kept store and the overflow bit before it is judged.
// max_gap is written through i_cfg, which is ready whenever reset is released;
// write it only while no item is in flight. It resets to 1.
//
// An item is judged by walking it through a row of CAPACITY cells, one cell
// per cycle, each holding one kept span. The probe's result is registered in
// the scan state, the verdict is written to the output register in the done
// state, and only then is the next item accepted; the walk through the cell
// row sets how long an item takes.
// The output register lets an item be accepted while the previous verdict is
// still waiting; if the receiver stalls, the finished verdict waits in the
// block and no further item is accepted until it can be written out.
// Reset clears the store, the count, the overflow bit and all valid bits at once.
module same_doc_adjacent_span_suppressor (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sdas_item_if.sink      i_in,
    sdas_verdict_if.source o_out,
    sdas_cfg_if.sink       i_cfg
);
    import sdas_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_word      r_max_gap;
    logic       r_inject;
    logic       r_found;
    logic       r_hit;
    t_word      r_cand;
    t_word      r_score;
    t_span      r_span;
    logic [CNT_W-1:0] r_count;
    logic       r_overflow;
    logic       r_out_valid;
    t_word      r_out_cand;
    t_word      r_out_score;
    logic       r_out_keep;
    logic       r_out_overflow;

    logic       w_accept;
    logic       w_clear;
    logic       w_finish;
    logic       w_keep;
    logic       w_store;
    logic       w_room;
    t_probe     w_probe_in;
    t_probe     w_probe_out;
    t_store_wr  w_wr;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_keep   = !r_found || !r_hit;
    assign w_store  = r_found && w_keep;
    assign w_room   = r_count < CNT_W'(CAPACITY);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_probe_out.act) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_in.ready = 1'b0;
        w_finish   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_in.ready = i_rst_n;
            end
            ST_DONE: begin
                w_finish = !r_out_valid || o_out.ready;
            end
            default: begin
                i_in.ready = 1'b0;
                w_finish   = 1'b0;
            end
        endcase
    end

    assign w_clear = w_accept && i_in.first;

    assign w_wr.en   = w_finish && w_store && w_room;
    assign w_wr.idx  = r_count[IDX_W-1:0];
    assign w_wr.span = r_span;

    assign w_probe_in.act  = r_inject;
    assign w_probe_in.hit  = 1'b0;
    assign w_probe_in.span = r_span;

    sdas_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_max_gap (r_max_gap),
        .i_clear   (w_clear),
        .i_wr      (w_wr),
        .i_probe   (w_probe_in),
        .o_probe   (w_probe_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_max_gap  <= WORD_W'(1);
            r_inject   <= 1'b0;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= w_accept;
            if (i_cfg.valid && i_cfg.ready) begin
                r_max_gap <= i_cfg.data;
            end
            if (w_clear) begin
                r_count    <= '0;
                r_overflow <= 1'b0;
            end else if (w_finish && w_store) begin
                if (w_room) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found       <= i_in.chunk_found;
            r_cand        <= i_in.candidate_id;
            r_score       <= i_in.score_bits;
            r_span.doc      <= i_in.doc_id;
            r_span.first_ln <= i_in.line_lo;
            r_span.last_ln  <= i_in.line_hi;
        end
        if (r_state == ST_SCAN && w_probe_out.act) begin
            r_hit <= w_probe_out.hit;
        end
        if (w_finish) begin
            r_out_cand     <= r_cand;
            r_out_score    <= r_score;
            r_out_keep     <= w_keep;
            r_out_overflow <= r_overflow || (w_store && !w_room);
        end
    end

    assign i_cfg.ready         = i_rst_n;
    assign o_out.valid         = r_out_valid;
    assign o_out.out_candidate = r_out_cand;
    assign o_out.out_score     = r_out_score;
    assign o_out.keep          = r_out_keep;
    assign o_out.overflow      = r_out_overflow;

endmodule
